[hdl/pffba_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pffba_pkg
// Shared types and constants for the paged first-fit bump allocator.
// ----------------------------------------------------------------------------
package pffba_pkg;

  localparam int MAX_PAGES = 16;
  localparam int PAGE_W    = 4;   // width of the page_index field
  localparam int CNT_W     = 5;   // width of the page_count field
  localparam int BYTE_W    = 16;

  localparam logic [BYTE_W-1:0] CAP_RESET = 16'd4072;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;

  localparam logic [CNT_W-1:0] PAGES_MAX = CNT_W'(MAX_PAGES);

  // request travelling down the row of page cells, newest page first
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [BYTE_W-1:0] count;
    logic [PAGE_W-1:0] page;
    logic [BYTE_W-1:0] offset;
  } token_t;

endpackage
`default_nettype wire

[hdl/pffba_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pffba_cell
// One page: holds its used byte count and grants a passing request that fits.
// ----------------------------------------------------------------------------
module pffba_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [pffba_pkg::PAGE_W-1:0]    cell_idx,
  input  wire logic                            cell_open,
  input  wire logic [pffba_pkg::BYTE_W-1:0]    page_capacity,
  input  wire logic                            clr,
  input  wire logic                            wr_en,
  input  wire logic [pffba_pkg::BYTE_W-1:0]    wr_data,
  input  wire pffba_pkg::token_t               tok_in,
  output pffba_pkg::token_t                    tok_out
);

  logic [pffba_pkg::BYTE_W-1:0] used_r, used_nxt;
  logic [pffba_pkg::BYTE_W-1:0] room;
  logic                         hit;
  pffba_pkg::token_t            tok_r, tok_nxt;

  // overfull page (capacity lowered) has no room
  assign room = (used_r >= page_capacity) ? '0 : (page_capacity - used_r);
  assign hit  = tok_in.vld && !tok_in.found && cell_open && (room >= tok_in.count);

  always_comb begin
    used_nxt = used_r;
    if (clr) begin
      used_nxt = '0;
    end else if (wr_en) begin
      used_nxt = wr_data;
    end else if (hit) begin
      used_nxt = used_r + tok_in.count;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.found  = 1'b1;
      tok_nxt.page   = cell_idx;
      tok_nxt.offset = used_r;
    end
  end

  always_ff @(posedge clk) begin
    used_r <= used_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.found  <= tok_nxt.found;
    tok_r.count  <= tok_nxt.count;
    tok_r.page   <= tok_nxt.page;
    tok_r.offset <= tok_nxt.offset;
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

[hdl/paged_first_fit_bump_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// paged_first_fit_bump_allocator
// Arena allocator over a row of page cells; first fit from the newest page.
// ----------------------------------------------------------------------------
// Flow: an allocate word walks the row of 16 page cells, one cell a cycle,
//   then waits in a hold register; release-all and oversized requests go
//   straight to it. From there each result moves to the output register.
// Throughput: one word at a time; the next word is taken the cycle after the
//   result has moved to the output register.
// Reset: synchronous, active low; no pages open, capacity 4072.
// ----------------------------------------------------------------------------
module paged_first_fit_bump_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_command,
  input  wire logic [pffba_pkg::BYTE_W-1:0]  in_byte_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic [pffba_pkg::PAGE_W-1:0]       out_page_index,
  output logic [pffba_pkg::BYTE_W-1:0]       out_offset,
  output logic                               out_opened_page,
  output logic [pffba_pkg::CNT_W-1:0]        out_page_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pffba_pkg::BYTE_W-1:0]  cfg_data
);

  logic [pffba_pkg::BYTE_W-1:0] cap_r;
  logic [pffba_pkg::CNT_W-1:0]  open_r, open_nxt;
  logic                         busy_r;

  logic                         hold_v_r, hold_rel_r, hold_big_r, hold_found_r;
  logic [pffba_pkg::PAGE_W-1:0] hold_page_r;
  logic [pffba_pkg::BYTE_W-1:0] hold_off_r, hold_cnt_r;

  logic                         out_valid_r, out_opened_r;
  logic [1:0]                   out_status_r;
  logic [pffba_pkg::PAGE_W-1:0] out_page_r;
  logic [pffba_pkg::BYTE_W-1:0] out_off_r;
  logic [pffba_pkg::CNT_W-1:0]  out_cnt_r;

  logic                         accept, is_rel, is_big, move, open_new;
  logic [1:0]                   status_nxt;
  logic [pffba_pkg::PAGE_W-1:0] page_nxt;
  logic [pffba_pkg::BYTE_W-1:0] off_nxt;
  logic                         opened_nxt;

  pffba_pkg::token_t            inj;
  pffba_pkg::token_t            tok [pffba_pkg::MAX_PAGES];

  assign in_ready  = !busy_r;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign is_rel    = accept && (in_command == pffba_pkg::CMD_RELEASE);
  assign is_big    = accept && (in_command == pffba_pkg::CMD_ALLOC) &&
                     (in_byte_count > cap_r);

  always_comb begin
    inj        = '0;
    inj.vld    = accept && !is_rel && !is_big;
    inj.count  = in_byte_count;
  end

  assign move = hold_v_r && (!out_valid_r || out_ready);

  // finishing a word: grant, open a fresh page, or report
  always_comb begin
    status_nxt = pffba_pkg::ST_OK;
    page_nxt   = '0;
    off_nxt    = '0;
    opened_nxt = 1'b0;
    open_new   = 1'b0;
    open_nxt   = open_r;
    if (hold_rel_r) begin
      status_nxt = pffba_pkg::ST_OK;
    end else if (hold_big_r) begin
      status_nxt = pffba_pkg::ST_TOO_BIG;
    end else if (hold_found_r) begin
      page_nxt = hold_page_r;
      off_nxt  = hold_off_r;
    end else if (open_r == pffba_pkg::PAGES_MAX) begin
      status_nxt = pffba_pkg::ST_FULL;
    end else begin
      open_new   = move;
      page_nxt   = open_r[pffba_pkg::PAGE_W-1:0];
      opened_nxt = 1'b1;
      open_nxt   = open_r + 1'b1;
    end
  end

  genvar g;
  generate
    for (g = 0; g < pffba_pkg::MAX_PAGES; g++) begin : g_cell
      pffba_pkg::token_t cin;
      if (g == pffba_pkg::MAX_PAGES - 1) begin : g_head
        assign cin = inj;
      end else begin : g_link
        assign cin = tok[g+1];
      end
      pffba_cell u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .cell_idx      (pffba_pkg::PAGE_W'(g)),
        .cell_open     (pffba_pkg::CNT_W'(g) < open_r),
        .page_capacity (cap_r),
        .clr           (is_rel),
        .wr_en         (open_new && (open_r[pffba_pkg::PAGE_W-1:0] == pffba_pkg::PAGE_W'(g))),
        .wr_data       (hold_cnt_r),
        .tok_in        (cin),
        .tok_out       (tok[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= pffba_pkg::CAP_RESET;
      open_r      <= '0;
      busy_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (move) begin
        busy_r <= 1'b0;
      end
      if (is_rel || is_big || tok[0].vld) begin
        hold_v_r <= 1'b1;
      end else if (move) begin
        hold_v_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
        open_r      <= open_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_rel || is_big) begin
      hold_rel_r   <= is_rel;
      hold_big_r   <= is_big;
      hold_found_r <= 1'b0;
    end else if (tok[0].vld) begin
      hold_rel_r   <= 1'b0;
      hold_big_r   <= 1'b0;
      hold_found_r <= tok[0].found;
      hold_page_r  <= tok[0].page;
      hold_off_r   <= tok[0].offset;
      hold_cnt_r   <= tok[0].count;
    end
    if (move) begin
      out_status_r <= status_nxt;
      out_page_r   <= page_nxt;
      out_off_r    <= off_nxt;
      out_opened_r <= opened_nxt;
      out_cnt_r    <= open_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_page_index  = out_page_r;
  assign out_offset      = out_off_r;
  assign out_opened_page = out_opened_r;
  assign out_page_count  = out_cnt_r;

endmodule
`default_nettype wire

[hdl/pffba_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pffba_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pffba_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic                          in_command,
  input  wire logic [pffba_pkg::BYTE_W-1:0]  in_byte_count,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [1:0]                    out_status,
  input  wire logic [pffba_pkg::PAGE_W-1:0]  out_page_index,
  input  wire logic [pffba_pkg::BYTE_W-1:0]  out_offset,
  input  wire logic                          out_opened_page,
  input  wire logic [pffba_pkg::CNT_W-1:0]   out_page_count,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [pffba_pkg::BYTE_W-1:0]  cfg_data
);

  // a stalled result word keeps its offset, page count and status
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_offset) &&
    $stable(out_page_count) && $stable(out_status))
    else $error("result word changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3 && out_page_count <= pffba_pkg::PAGES_MAX)
    else $error("status or page count out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pffba_pkg::ST_OK |->
    out_page_index == '0 && out_offset == '0 && !out_opened_page)
    else $error("error result carries a grant");

  // a freshly opened page is the newest and starts empty
  a_open_newest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_opened_page |->
    out_offset == '0 && (pffba_pkg::CNT_W'(out_page_index) + 1'b1) == out_page_count)
    else $error("opened page is not the newest");

endmodule

bind paged_first_fit_bump_allocator pffba_checker u_pffba_checker (.*);
`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the paged first-fit bump allocator.
// A short table of directed words, including the full and oversize cases,
// is followed by randomised phases at several page capacities. Every word is
// scored against an in-bench allocator model or its table entry, with random
// idling on both channels and one long output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STUCK_LIMIT    = 2000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int PHASES         = 10;
  localparam int PHASE_WORDS    = 125;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic [1:0]                   status;
    logic [pffba_pkg::PAGE_W-1:0] page;
    logic [pffba_pkg::BYTE_W-1:0] offset;
    logic                         opened;
    logic [pffba_pkg::CNT_W-1:0]  count;
  } grant_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic                         cmd;
    logic [pffba_pkg::BYTE_W-1:0] arg;
    int                           reps;
    bit                           typed;
    grant_t                       want;
  } dir_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_command;
  logic [pffba_pkg::BYTE_W-1:0] in_byte_count;
  logic                         out_valid;
  logic                         out_ready;
  logic [1:0]                   out_status;
  logic [pffba_pkg::PAGE_W-1:0] out_page_index;
  logic [pffba_pkg::BYTE_W-1:0] out_offset;
  logic                         out_opened_page;
  logic [pffba_pkg::CNT_W-1:0]  out_page_count;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [pffba_pkg::BYTE_W-1:0] cfg_data;

  paged_first_fit_bump_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_byte_count   (in_byte_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_page_index  (out_page_index),
    .out_offset      (out_offset),
    .out_opened_page (out_opened_page),
    .out_page_count  (out_page_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // allocator model state
  logic [pffba_pkg::BYTE_W-1:0] capacity;
  int                           pages_open;
  logic [pffba_pkg::BYTE_W-1:0] used [pffba_pkg::MAX_PAGES];

  grant_t   grant_q [$];
  dir_row_t dir_tab [$];

  bit     use_typed;
  grant_t typed_grant;
  bit     squeeze_req;
  int     gap_pct;
  int     stall_pct;
  int     fails;
  int     n_words, n_checked, n_cfg, n_full, n_too_big, n_release, n_opened;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [pffba_pkg::BYTE_W-1:0] room_left(input int p);
    return (used[p] >= capacity) ? '0 : capacity - used[p];
  endfunction

  // one step of the allocator: newest open page first, else open a new one
  function automatic grant_t serve_request(input logic cmd,
                                           input logic [pffba_pkg::BYTE_W-1:0] cnt);
    grant_t g;
    int     hit;
    g   = '0;
    hit = -1;
    if (cmd == pffba_pkg::CMD_RELEASE) begin
      for (int p = 0; p < pages_open; p++) used[p] = '0;
    end else if (cnt > capacity) begin
      g.status = pffba_pkg::ST_TOO_BIG;
    end else begin
      for (int p = pages_open - 1; p >= 0; p--)
        if (hit < 0 && room_left(p) >= cnt) hit = p;
      if (hit < 0 && pages_open >= pffba_pkg::MAX_PAGES) begin
        g.status = pffba_pkg::ST_FULL;
      end else begin
        if (hit < 0) begin
          hit        = pages_open;
          used[hit]  = '0;
          pages_open = pages_open + 1;
          g.opened   = 1'b1;
        end
        g.page    = pffba_pkg::PAGE_W'(hit);
        g.offset  = used[hit];
        used[hit] = used[hit] + cnt;
      end
    end
    g.count = pffba_pkg::CNT_W'(pages_open);
    return g;
  endfunction

  function automatic grant_t gr(input logic [1:0] st, input int pg, input int off,
                                input logic op, input int pc);
    grant_t g;
    g.status = st;
    g.page   = pffba_pkg::PAGE_W'(pg);
    g.offset = pffba_pkg::BYTE_W'(off);
    g.opened = op;
    g.count  = pffba_pkg::CNT_W'(pc);
    return g;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic cmd,
                                  input logic [pffba_pkg::BYTE_W-1:0] arg,
                                  input int reps, input bit typed,
                                  input grant_t want);
    dir_row_t r;
    r.kind  = kind;
    r.cmd   = cmd;
    r.arg   = arg;
    r.reps  = reps;
    r.typed = typed;
    r.want  = want;
    dir_tab.push_back(r);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_gap();
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) return pick_gap();
    return 0;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // ends at a falling edge, ready to offer the next word
  task automatic pause_input(input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic offer(input logic cmd, input logic [pffba_pkg::BYTE_W-1:0] cnt,
                       input bit typed, input grant_t want);
    use_typed     = typed;
    typed_grant   = want;
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_byte_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // register writes only with the block drained
  task automatic set_capacity(input logic [pffba_pkg::BYTE_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    grant_t want;
    grant_t seen;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
        n_cfg++;
      end
      if (in_valid && in_ready) begin
        want = serve_request(in_command, in_byte_count);
        if (use_typed) want = typed_grant;
        grant_q.push_back(want);
        n_words++;
      end
      if (out_valid && out_ready) begin
        seen.status = out_status;
        seen.page   = out_page_index;
        seen.offset = out_offset;
        seen.opened = out_opened_page;
        seen.count  = out_page_count;
        if (grant_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: result word with nothing expected, got status %0d page %0d",
                     $time, seen.status, seen.page);
        end else begin
          want = grant_q.pop_front();
          check_field("status", want.status, seen.status);
          check_field("page_index", want.page, seen.page);
          check_field("offset", want.offset, seen.offset);
          check_field("opened_page", want.opened, seen.opened);
          check_field("page_count", want.count, seen.count);
          n_checked++;
          if (want.status == pffba_pkg::ST_FULL) n_full++;
          if (want.status == pffba_pkg::ST_TOO_BIG) n_too_big++;
          if (want.opened) n_opened++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int stuck;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, stuck);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : receiver
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold        = SQUEEZE_CYCLES;
      end else if (hold == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [pffba_pkg::BYTE_W-1:0] caps [PHASES];
    logic [pffba_pkg::BYTE_W-1:0] cnt;
    logic                         cmd;
    int                           cap_i;
    int                           r;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = pffba_pkg::CMD_ALLOC;
    in_byte_count = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    use_typed     = 1'b0;
    typed_grant   = '0;
    squeeze_req   = 1'b0;
    gap_pct       = 30;
    stall_pct     = 25;
    fails         = 0;
    n_words = 0; n_checked = 0; n_cfg = 0;
    n_full = 0; n_too_big = 0; n_release = 0; n_opened = 0;
    capacity   = pffba_pkg::CAP_RESET;
    pages_open = 0;
    for (int p = 0; p < pffba_pkg::MAX_PAGES; p++) used[p] = '0;

    // directed table
    add_row(ROW_WORD, pffba_pkg::CMD_RELEASE, 16'd0,    1, 1,
            gr(pffba_pkg::ST_OK, 0, 0, 0, 0));
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'hFFFF, 1, 1,
            gr(pffba_pkg::ST_TOO_BIG, 0, 0, 0, 0));
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd4073, 1, 1,
            gr(pffba_pkg::ST_TOO_BIG, 0, 0, 0, 0));
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd0,    1, 1,
            gr(pffba_pkg::ST_OK, 0, 0, 1, 1));
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd4072, 1, 1,
            gr(pffba_pkg::ST_OK, 0, 0, 0, 1));
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd0,    1, 1,
            gr(pffba_pkg::ST_OK, 0, 4072, 0, 1));
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd1,    1, 1,
            gr(pffba_pkg::ST_OK, 1, 0, 1, 2));
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd100,  1, 0, '0);
    add_row(ROW_WORD, pffba_pkg::CMD_RELEASE, 16'hFFFF, 1, 1,
            gr(pffba_pkg::ST_OK, 0, 0, 0, 2));
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd4072, 1, 0, '0);
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd10,   1, 0, '0);  // older page takes it
    add_row(ROW_CFG,  pffba_pkg::CMD_ALLOC,   16'hFFFF, 1, 0, '0);
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'hFFFF, 1, 0, '0);
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'h8000, 1, 0, '0);
    add_row(ROW_CFG,  pffba_pkg::CMD_ALLOC,   16'd1,    1, 0, '0);  // every page now over-used
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd1,    1, 0, '0);
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd2,    1, 0, '0);
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd1,   12, 0, '0);  // opens the remaining pages
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd1,    1, 1,
            gr(pffba_pkg::ST_FULL, 0, 0, 0, 16));
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd0,    1, 0, '0);
    add_row(ROW_WORD, pffba_pkg::CMD_RELEASE, 16'd0,    1, 1,
            gr(pffba_pkg::ST_OK, 0, 0, 0, 16));
    add_row(ROW_WORD, pffba_pkg::CMD_ALLOC,   16'd1,    1, 0, '0);
    add_row(ROW_CFG,  pffba_pkg::CMD_ALLOC,   pffba_pkg::CAP_RESET, 1, 0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_tab.size(); i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        set_capacity(dir_tab[i].arg);
      end else begin
        repeat (dir_tab[i].reps) begin
          pause_input(next_gap());
          offer(dir_tab[i].cmd, dir_tab[i].arg, dir_tab[i].typed, dir_tab[i].want);
        end
      end
    end

    caps = '{pffba_pkg::CAP_RESET, 16'hFFFF, 16'd1, 16'd64, 16'd1000, 16'd0, 16'd0,
             16'hFFFE, 16'h8000, 16'd0};
    for (int ph = 0; ph < PHASES; ph++) begin
      // zero entries pick a random capacity
      set_capacity(caps[ph] != 0 ? caps[ph]
                                 : pffba_pkg::BYTE_W'($urandom_range(1, 65535)));
      gap_pct   = (ph % 3 == 0) ? 0 : 30;
      stall_pct = (ph % 3 == 0) ? 0 : 25;
      if (ph == 4) begin
        gap_pct = 0;
        @(posedge clk);
        squeeze_req = 1'b1;
      end
      for (int k = 0; k < PHASE_WORDS; k++) begin
        pause_input(next_gap());
        cap_i = capacity;
        cmd   = pffba_pkg::CMD_ALLOC;
        r     = $urandom_range(0, 99);
        if (r < 7) begin
          cmd = pffba_pkg::CMD_RELEASE;
          cnt = pffba_pkg::BYTE_W'($urandom);
          n_release++;
        end else if (r < 13) begin
          cnt = (cap_i < 65535) ? pffba_pkg::BYTE_W'($urandom_range(cap_i + 1, 65535))
                                : pffba_pkg::BYTE_W'($urandom);
        end else if (r < 20) begin
          cnt = '0;
        end else if (r < 35) begin
          cnt = room_left($urandom_range(0, pffba_pkg::MAX_PAGES - 1));  // exact fit
        end else if (r < 75) begin
          cnt = pffba_pkg::BYTE_W'($urandom_range(0, cap_i / 8 + 1));
        end else begin
          cnt = pffba_pkg::BYTE_W'($urandom_range(0, cap_i));
        end
        offer(cmd, cnt, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d of %0d words over %0d capacity writes.", n_checked, n_words, n_cfg);
    $display("Pages opened %0d, full %0d, oversize %0d, random release-all %0d.",
             n_opened, n_full, n_too_big, n_release);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fails);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/pffba_pkg.sv
hdl/pffba_cell.sv
hdl/paged_first_fit_bump_allocator.sv
hdl/pffba_checker.sv
dv/tb_top.sv
